// ===== rtl/core/eit_pkg.sv =====
// eit_pkg: shared types, widths and register codes for the epipolar inlier test
// no dependencies; imported by every module in rtl/core
package eit_pkg;

	// payload of one correspondence and one verdict
	typedef struct packed {
		logic signed [23:0] first_x;
		logic signed [23:0] first_y;
		logic signed [23:0] second_x;
		logic signed [23:0] second_y;
		logic               pair_last;
	} pair_t;

	typedef struct packed {
		logic        is_inlier;
		logic [31:0] abs_distance;
		logic        degenerate;
		logic        result_last;
	} verdict_t;

	// control that travels with each item down the pipeline
	typedef struct packed {
		logic valid;
		logic last;
		logic degen;
	} tag_t;

	// fundamental matrix, row major, signed q2.29 entries
	typedef logic [2:0][2:0][31:0] fmat_t;

	localparam int LINE_W    = 57;  // signed line component
	localparam int MAG_W     = 56;  // line component magnitude
	localparam int GRP_N     = 7;   // 8-bit groups in a magnitude
	localparam int NORM_BITS = 29;  // normalized normal magnitude bits
	localparam int RAD_W     = 59;  // lx'^2 + ly'^2
	localparam int ROOT_W    = 30;
	localparam int SQ_STEPS  = 30;
	localparam int DM_W      = 63;  // |dot|
	localparam int DIV_STEPS = 32;

	localparam logic [MAG_W-1:0] LZ_LIMIT = MAG_W'(1) << 54;
	localparam logic [31:0]      SAT32    = 32'hFFFF_FFFF;

	// line and point handed to one normalize lane
	typedef struct packed {
		logic signed [LINE_W-1:0] lx;
		logic signed [LINE_W-1:0] ly;
		logic signed [LINE_W-1:0] lz;
		logic signed [23:0]       px;
		logic signed [23:0]       py;
	} line_t;

	// register indexes on the configuration port
	localparam logic [2:0] REG_COEF_A = 3'd0;
	localparam logic [2:0] REG_COEF_B = 3'd1;
	localparam logic [2:0] REG_COEF_C = 3'd2;
	localparam logic [2:0] REG_COEF_D = 3'd3;
	localparam logic [2:0] REG_COEF_E = 3'd4;
	localparam logic [2:0] REG_LIMIT  = 3'd5;

endpackage

// ===== rtl/core/eit_line_gen.sv =====
// eit_line_gen: epipolar lines l1 = F*p1 and l2 = F^T*p2, two register stages
// depends on eit_pkg
module eit_line_gen import eit_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  fmat_t fm,
	input  logic  valid,
	input  pair_t pair,
	output line_t line_a,
	output line_t line_b,
	output tag_t  tag
);

	logic signed [55:0] p1x_s1 [3];
	logic signed [55:0] p1y_s1 [3];
	logic signed [55:0] p2x_s1 [3];
	logic signed [55:0] p2y_s1 [3];
	pair_t              pair_s1;
	tag_t               tag_s1;
	line_t              la_s2;
	line_t              lb_s2;
	tag_t               tag_s2;
	logic signed [LINE_W-1:0] l1 [3];
	logic signed [LINE_W-1:0] l2 [3];

	// stage 1: products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p1x_s1[i] <= 56'($signed(fm[i][0])) * 56'(pair.first_x);
			p1y_s1[i] <= 56'($signed(fm[i][1])) * 56'(pair.first_y);
			p2x_s1[i] <= 56'($signed(fm[0][i])) * 56'(pair.second_x);
			p2y_s1[i] <= 56'($signed(fm[1][i])) * 56'(pair.second_y);
		end
		pair_s1 <= pair;
	end

	// stage 2: sums, homogeneous one is 256
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			l1[i] = LINE_W'(p1x_s1[i]) + LINE_W'(p1y_s1[i])
				+ (LINE_W'($signed(fm[i][2])) <<< 8);
			l2[i] = LINE_W'(p2x_s1[i]) + LINE_W'(p2y_s1[i])
				+ (LINE_W'($signed(fm[2][i])) <<< 8);
		end
	end

	always_ff @(posedge clk) begin
		la_s2 <= '{lx: l1[0], ly: l1[1], lz: l1[2],
			px: pair_s1.second_x, py: pair_s1.second_y};
		lb_s2 <= '{lx: l2[0], ly: l2[1], lz: l2[2],
			px: pair_s1.first_x, py: pair_s1.first_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= '{valid: valid, last: pair.pair_last, degen: 1'b0};
			tag_s2 <= tag_s1;
		end
	end

	assign line_a = la_s2;
	assign line_b = lb_s2;
	assign tag    = tag_s2;

endmodule

// ===== rtl/core/eit_norm.sv =====
// eit_norm: normalizes one line, forms |point . line| and the normal's squared length
// depends on eit_pkg; eight register stages
module eit_norm import eit_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  line_t            line,
	input  tag_t             tag_in,
	output logic [RAD_W-1:0] rad,
	output logic [DM_W-1:0]  dm,
	output tag_t             tag
);

	// stage 1
	logic [MAG_W-1:0]   ax_s1, ay_s1, az_s1, m_s1;
	logic               nx_s1, ny_s1, nz_s1;
	logic signed [23:0] px_s1, py_s1;
	tag_t               tag_s1;
	logic [LINE_W-1:0]  tx, ty, tz;
	logic [MAG_W-1:0]   ax, ay;

	always_comb begin
		tx = line.lx[LINE_W-1] ? LINE_W'(-line.lx) : LINE_W'(line.lx);
		ty = line.ly[LINE_W-1] ? LINE_W'(-line.ly) : LINE_W'(line.ly);
		tz = line.lz[LINE_W-1] ? LINE_W'(-line.lz) : LINE_W'(line.lz);
		ax = tx[MAG_W-1:0];
		ay = ty[MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		ax_s1 <= ax;
		ay_s1 <= ay;
		az_s1 <= tz[MAG_W-1:0];
		m_s1  <= (ax > ay) ? ax : ay;
		nx_s1 <= line.lx[LINE_W-1];
		ny_s1 <= line.ly[LINE_W-1];
		nz_s1 <= line.lz[LINE_W-1];
		px_s1 <= line.px;
		py_s1 <= line.py;
	end

	// stage 2: leading one inside each byte group
	logic [MAG_W-1:0]      ax_s2, ay_s2, az_s2;
	logic                  nx_s2, ny_s2, nz_s2;
	logic signed [23:0]    px_s2, py_s2;
	tag_t                  tag_s2;
	logic [GRP_N-1:0]      gnz_s2, gnz;
	logic [GRP_N-1:0][2:0] gpos_s2, gpos;

	always_comb begin
		for (int g = 0; g < GRP_N; g++) begin
			gnz[g]  = |m_s1[g*8 +: 8];
			gpos[g] = 3'd0;
			for (int k = 0; k < 8; k++) begin
				if (m_s1[g*8 + k]) begin
					gpos[g] = 3'(k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		az_s2   <= az_s1;
		nx_s2   <= nx_s1;
		ny_s2   <= ny_s1;
		nz_s2   <= nz_s1;
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		gnz_s2  <= gnz;
		gpos_s2 <= gpos;
	end

	// stage 3: bit length of the larger component
	logic [MAG_W-1:0]   ax_s3, ay_s3, az_s3;
	logic               nx_s3, ny_s3, nz_s3;
	logic signed [23:0] px_s3, py_s3;
	tag_t               tag_s3;
	logic [5:0]         blen_s3, blen;

	always_comb begin
		blen = 6'd0;
		for (int g = 0; g < GRP_N; g++) begin
			if (gnz_s2[g]) begin
				blen = 6'(g * 8) + 6'(gpos_s2[g]) + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ax_s3   <= ax_s2;
		ay_s3   <= ay_s2;
		az_s3   <= az_s2;
		nx_s3   <= nx_s2;
		ny_s3   <= ny_s2;
		nz_s3   <= nz_s2;
		px_s3   <= px_s2;
		py_s3   <= py_s2;
		blen_s3 <= blen;
	end

	// stage 4: shift so the larger component has exactly NORM_BITS bits
	logic [NORM_BITS-1:0] axn_s4, ayn_s4, axn, ayn;
	logic [MAG_W-1:0]     azn_s4, azn;
	logic                 over_s4, over;
	logic                 nx_s4, ny_s4, nz_s4;
	logic signed [23:0]   px_s4, py_s4;
	tag_t                 tag_s4;
	logic [5:0]           sh;
	logic [MAG_W-1:0]     axw, ayw;

	always_comb begin
		if (blen_s3 >= 6'(NORM_BITS)) begin
			sh   = blen_s3 - 6'(NORM_BITS);
			axw  = ax_s3 >> sh;
			ayw  = ay_s3 >> sh;
			azn  = az_s3 >> sh;
			over = 1'b0;
		end else begin
			sh   = 6'(NORM_BITS) - blen_s3;
			axw  = ax_s3 << sh;
			ayw  = ay_s3 << sh;
			azn  = az_s3 << sh;
			over = az_s3 > (LZ_LIMIT >> sh);
		end
		axn = axw[NORM_BITS-1:0];
		ayn = ayw[NORM_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		axn_s4  <= axn;
		ayn_s4  <= ayn;
		azn_s4  <= azn;
		over_s4 <= over;
		nx_s4   <= nx_s3;
		ny_s4   <= ny_s3;
		nz_s4   <= nz_s3;
		px_s4   <= px_s3;
		py_s4   <= py_s3;
	end

	// stage 5: clamp lz, restore signs, square the normal
	logic signed [NORM_BITS:0] sx_s5, sy_s5;
	logic signed [MAG_W-1:0]   sz_s5;
	logic [57:0]               sqx_s5, sqy_s5;
	logic signed [23:0]        px_s5, py_s5;
	tag_t                      tag_s5;
	logic [MAG_W-1:0]          azc;
	logic signed [NORM_BITS:0] ux, uy;
	logic signed [MAG_W-1:0]   uz;

	always_comb begin
		azc = (over_s4 || azn_s4 > LZ_LIMIT) ? LZ_LIMIT : azn_s4;
		ux  = $signed({1'b0, axn_s4});
		uy  = $signed({1'b0, ayn_s4});
		uz  = $signed(azc);
	end

	always_ff @(posedge clk) begin
		sx_s5  <= nx_s4 ? -ux : ux;
		sy_s5  <= ny_s4 ? -uy : uy;
		sz_s5  <= nz_s4 ? -uz : uz;
		sqx_s5 <= 58'(axn_s4) * 58'(axn_s4);
		sqy_s5 <= 58'(ayn_s4) * 58'(ayn_s4);
		px_s5  <= px_s4;
		py_s5  <= py_s4;
	end

	// stage 6: point times normal
	logic signed [53:0]      prx_s6, pry_s6;
	logic signed [MAG_W-1:0] sz_s6;
	logic [RAD_W-1:0]        rad_s6;
	tag_t                    tag_s6;

	always_ff @(posedge clk) begin
		prx_s6 <= 54'(px_s5) * 54'(sx_s5);
		pry_s6 <= 54'(py_s5) * 54'(sy_s5);
		sz_s6  <= sz_s5;
		rad_s6 <= RAD_W'(sqx_s5) + RAD_W'(sqy_s5);
	end

	// stage 7: dot product
	logic signed [63:0] dot_s7;
	logic [RAD_W-1:0]   rad_s7;
	tag_t               tag_s7;

	always_ff @(posedge clk) begin
		dot_s7 <= 64'(prx_s6) + 64'(pry_s6) + (64'(sz_s6) <<< 8);
		rad_s7 <= rad_s6;
	end

	// stage 8: magnitude of the dot product
	logic [DM_W-1:0]  dm_s8;
	logic [RAD_W-1:0] rad_s8;
	tag_t             tag_s8;
	logic [63:0]      dabs;

	assign dabs = dot_s7[63] ? 64'(-dot_s7) : 64'(dot_s7);

	always_ff @(posedge clk) begin
		dm_s8  <= dabs[DM_W-1:0];
		rad_s8 <= rad_s7;
	end

	// control: a zero normal marks the item degenerate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
			tag_s8 <= '0;
		end else begin
			tag_s1 <= '{valid: tag_in.valid, last: tag_in.last,
				degen: tag_in.degen | ((ax == '0) && (ay == '0))};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
		end
	end

	assign rad = rad_s8;
	assign dm  = dm_s8;
	assign tag = tag_s8;

endmodule

// ===== rtl/core/eit_sqrt.sv =====
// eit_sqrt: pipelined integer square root, one result bit per stage
// depends on eit_pkg; carries |dot| and the item tag alongside
module eit_sqrt import eit_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RAD_W-1:0]  rad,
	input  logic [DM_W-1:0]   dm_in,
	input  tag_t              tag_in,
	output logic [ROOT_W-1:0] root,
	output logic [DM_W-1:0]   dm,
	output tag_t              tag
);

	logic [31:0]       rem_s  [0:SQ_STEPS];
	logic [ROOT_W-1:0] root_s [0:SQ_STEPS];
	logic [59:0]       rad_s  [0:SQ_STEPS];
	logic [DM_W-1:0]   dm_s   [0:SQ_STEPS];
	tag_t              tag_s  [0:SQ_STEPS];

	logic [31:0]       rem_n  [SQ_STEPS];
	logic [ROOT_W-1:0] root_n [SQ_STEPS];
	logic [33:0]       cur, trial;

	// restoring square root step: two radicand bits in, one root bit out
	always_comb begin
		for (int i = 0; i < SQ_STEPS; i++) begin
			cur   = {rem_s[i], rad_s[i][59:58]};
			trial = {2'b00, root_s[i], 2'b01};
			if (cur >= trial) begin
				rem_n[i]  = 32'(cur - trial);
				root_n[i] = {root_s[i][ROOT_W-2:0], 1'b1};
			end else begin
				rem_n[i]  = cur[31:0];
				root_n[i] = {root_s[i][ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		root_s[0] <= '0;
		rad_s[0]  <= {1'b0, rad};
		dm_s[0]   <= dm_in;
		for (int i = 0; i < SQ_STEPS; i++) begin
			rem_s[i+1]  <= rem_n[i];
			root_s[i+1] <= root_n[i];
			rad_s[i+1]  <= rad_s[i] << 2;
			dm_s[i+1]   <= dm_s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= SQ_STEPS; i++) begin
				tag_s[i] <= '0;
			end
		end else begin
			tag_s[0] <= tag_in;
			for (int i = 0; i < SQ_STEPS; i++) begin
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign root = root_s[SQ_STEPS];
	assign dm   = dm_s[SQ_STEPS];
	assign tag  = tag_s[SQ_STEPS];

endmodule

// ===== rtl/core/eit_div.sv =====
// eit_div: pipelined restoring divider |dot| / root, one quotient bit per stage
// depends on eit_pkg; quotients of 2^32 or more are flagged for saturation
module eit_div import eit_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ROOT_W-1:0] divisor,
	input  logic [DM_W-1:0]   dm,
	input  tag_t              tag_in,
	output logic [31:0]       quo,
	output logic              ovf,
	output tag_t              tag
);

	logic [ROOT_W-1:0] rem_s [0:DIV_STEPS];
	logic [ROOT_W-1:0] dvs_s [0:DIV_STEPS];
	logic [31:0]       low_s [0:DIV_STEPS];
	logic [31:0]       quo_s [0:DIV_STEPS];
	logic              ovf_s [0:DIV_STEPS];
	tag_t              tag_s [0:DIV_STEPS];

	logic [ROOT_W-1:0] rem_n [DIV_STEPS];
	logic              qb_n  [DIV_STEPS];
	logic [ROOT_W:0]   cur;

	always_comb begin
		for (int i = 0; i < DIV_STEPS; i++) begin
			cur = {rem_s[i], low_s[i][31]};
			if (cur >= {1'b0, dvs_s[i]}) begin
				rem_n[i] = ROOT_W'(cur - {1'b0, dvs_s[i]});
				qb_n[i]  = 1'b1;
			end else begin
				rem_n[i] = cur[ROOT_W-1:0];
				qb_n[i]  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		// the upper part is below the divisor unless the quotient overflows
		ovf_s[0] <= dm >= {1'b0, divisor, 32'd0};
		rem_s[0] <= dm[ROOT_W+31:32];
		low_s[0] <= dm[31:0];
		dvs_s[0] <= divisor;
		quo_s[0] <= '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			ovf_s[i+1] <= ovf_s[i];
			rem_s[i+1] <= rem_n[i];
			low_s[i+1] <= low_s[i] << 1;
			dvs_s[i+1] <= dvs_s[i];
			quo_s[i+1] <= {quo_s[i][30:0], qb_n[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STEPS; i++) begin
				tag_s[i] <= '0;
			end
		end else begin
			tag_s[0] <= tag_in;
			for (int i = 0; i < DIV_STEPS; i++) begin
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign quo = quo_s[DIV_STEPS];
	assign ovf = ovf_s[DIV_STEPS];
	assign tag = tag_s[DIV_STEPS];

endmodule

// ===== rtl/core/epipolar_inlier_test.sv =====
// epipolar_inlier_test: symmetric epipolar distance inlier test, top level
// depends on eit_pkg, eit_line_gen, eit_norm, eit_sqrt, eit_div
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+----------------------------
//  input     | start && !busy at clk rise       | point_pair (pair_t)
//  result    | done high for one cycle          | verdict (verdict_t)
//  config    | psel && penable && pwrite        | paddr, pwdata / prdata
//
// one transaction enters per cycle; busy is never raised
// items pass in order through the lines, normalize and dot product, the square root,
// the divider, then sum and compare
// the square root and divider pipelines, one bit per stage, set the depth
// reset clears the valid bits and the registers (limit resets to 2.0 pixels)
// the receiver cannot stall, so the pipeline never holds
module epipolar_inlier_test import eit_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pair_t       point_pair,
	output logic        done,
	output verdict_t    verdict,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	// configuration registers, one per 8-byte slot
	logic [63:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic [31:0] coef_e_q, limit_q;
	logic [2:0]  reg_idx;
	fmat_t       fm;

	assign reg_idx = paddr[5:3];
	assign pready  = 1'b1;
	assign busy    = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
			coef_d_q <= '0;
			coef_e_q <= '0;
			limit_q  <= 32'd512;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_COEF_A: coef_a_q <= pwdata;
				REG_COEF_B: coef_b_q <= pwdata;
				REG_COEF_C: coef_c_q <= pwdata;
				REG_COEF_D: coef_d_q <= pwdata;
				REG_COEF_E: coef_e_q <= pwdata[31:0];
				REG_LIMIT:  limit_q  <= pwdata[31:0];
				default: ;  // unmapped slots ignore the write
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_COEF_A: prdata = coef_a_q;
			REG_COEF_B: prdata = coef_b_q;
			REG_COEF_C: prdata = coef_c_q;
			REG_COEF_D: prdata = coef_d_q;
			REG_COEF_E: prdata = {32'd0, coef_e_q};
			REG_LIMIT:  prdata = {32'd0, limit_q};
			default:    prdata = '0;
		endcase
	end

	// unpack F, row major; upper half of each pair comes first
	always_comb begin
		fm[0][0] = coef_a_q[63:32];
		fm[0][1] = coef_a_q[31:0];
		fm[0][2] = coef_b_q[63:32];
		fm[1][0] = coef_b_q[31:0];
		fm[1][1] = coef_c_q[63:32];
		fm[1][2] = coef_c_q[31:0];
		fm[2][0] = coef_d_q[63:32];
		fm[2][1] = coef_d_q[31:0];
		fm[2][2] = coef_e_q;
	end

	// epipolar lines: lane a is l1 against point 2, lane b is l2 against point 1
	line_t line_a, line_b;
	tag_t  tag_lg;

	eit_line_gen u_line_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.fm     (fm),
		.valid  (start && !busy),
		.pair   (point_pair),
		.line_a (line_a),
		.line_b (line_b),
		.tag    (tag_lg)
	);

	logic [RAD_W-1:0]  rad_a, rad_b;
	logic [DM_W-1:0]   dmn_a, dmn_b, dms_a, dms_b;
	tag_t              tag_na, tag_nb, tag_sa, tag_sb, tag_da, tag_db;
	logic [ROOT_W-1:0] root_a, root_b;
	logic [31:0]       quo_a, quo_b;
	logic              ovf_a, ovf_b;

	eit_norm u_norm_a (
		.clk (clk), .arst_n (arst_n), .line (line_a), .tag_in (tag_lg),
		.rad (rad_a), .dm (dmn_a), .tag (tag_na)
	);

	eit_norm u_norm_b (
		.clk (clk), .arst_n (arst_n), .line (line_b), .tag_in (tag_lg),
		.rad (rad_b), .dm (dmn_b), .tag (tag_nb)
	);

	eit_sqrt u_sqrt_a (
		.clk (clk), .arst_n (arst_n), .rad (rad_a), .dm_in (dmn_a),
		.tag_in (tag_na), .root (root_a), .dm (dms_a), .tag (tag_sa)
	);

	eit_sqrt u_sqrt_b (
		.clk (clk), .arst_n (arst_n), .rad (rad_b), .dm_in (dmn_b),
		.tag_in (tag_nb), .root (root_b), .dm (dms_b), .tag (tag_sb)
	);

	eit_div u_div_a (
		.clk (clk), .arst_n (arst_n), .divisor (root_a), .dm (dms_a),
		.tag_in (tag_sa), .quo (quo_a), .ovf (ovf_a), .tag (tag_da)
	);

	eit_div u_div_b (
		.clk (clk), .arst_n (arst_n), .divisor (root_b), .dm (dms_b),
		.tag_in (tag_sb), .quo (quo_b), .ovf (ovf_b), .tag (tag_db)
	);

	// sum the two point-line distances, each saturated, then the sum
	logic [31:0] term_a, term_b, dist_sat;
	logic [32:0] dsum;
	logic        degen;
	logic [31:0] dist_s1;
	logic        degen_s1, last_s1, valid_s1;

	always_comb begin
		term_a   = ovf_a ? SAT32 : quo_a;
		term_b   = ovf_b ? SAT32 : quo_b;
		dsum     = 33'(term_a) + 33'(term_b);
		degen    = tag_da.degen | tag_db.degen;
		// a zero normal forces the distance to full scale
		dist_sat = (dsum[32] || degen) ? SAT32 : dsum[31:0];
	end

	always_ff @(posedge clk) begin
		dist_s1  <= dist_sat;
		degen_s1 <= degen;
		last_s1  <= tag_da.last;
	end

	// compare against the limit and register the result transaction
	verdict_t verdict_s2;
	logic     done_s2;

	always_ff @(posedge clk) begin
		verdict_s2.is_inlier    <= !degen_s1 && (dist_s1 < limit_q);
		verdict_s2.abs_distance <= dist_s1;
		verdict_s2.degenerate   <= degen_s1;
		verdict_s2.result_last  <= last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= tag_da.valid & tag_db.valid;
			done_s2  <= valid_s1;
		end
	end

	assign done    = done_s2;
	assign verdict = verdict_s2;

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for the epipolar inlier test block
// depends on eit_pkg and rtl/core/epipolar_inlier_test; predicts or hand-types each verdict and compares
`timescale 1ns / 1ps

module testbench;
	import eit_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	pair_t       point_pair = '0;
	logic        done;
	verdict_t    verdict;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	epipolar_inlier_test dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_pair(point_pair), .done(done), .verdict(verdict),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// local copy of the matrix and threshold, updated with each register write
	longint   fm [3][3];
	bit [31:0] limit_q8 = 32'd512;

	// verdicts still owed by the block, oldest first
	verdict_t verdicts_due [$];
	bit       mismatch_seen = 1'b0;

	// a directed row may carry a hand-typed verdict instead of the predicted one
	bit       row_typed = 1'b0;
	verdict_t row_verdict;

	typedef struct {
		pair_t    p;
		bit       typed;
		verdict_t v;
	} row_t;

	localparam logic [31:0] ONE_F = 32'h2000_0000;  // 1.0 in q2.29

	function automatic longint unsigned mag64(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// point-to-line distance in q24.8 after scaling the normal to 29 bits
	function automatic longint unsigned point_line_dist(longint lx, longint ly, longint lz,
			longint px, longint py);
		longint unsigned ax, ay, az, m, s, q, lz_cap;
		longint sx, sy, sz, dot;
		int nb, k;
		ax = mag64(lx);
		ay = mag64(ly);
		az = mag64(lz);
		lz_cap = 64'd1 << 54;
		m = ax > ay ? ax : ay;
		nb = 0;
		while (m != 0) begin
			nb++;
			m >>= 1;
		end
		k = nb - NORM_BITS;
		if (k >= 0) begin
			ax >>= k;
			ay >>= k;
			az >>= k;
		end else begin
			ax <<= -k;
			ay <<= -k;
			if (az > (lz_cap >> -k))
				az = lz_cap;
			else
				az <<= -k;
		end
		if (az > lz_cap)
			az = lz_cap;
		sx = lx < 0 ? -longint'(ax) : longint'(ax);
		sy = ly < 0 ? -longint'(ay) : longint'(ay);
		sz = lz < 0 ? -longint'(az) : longint'(az);
		dot = px * sx + py * sy + 256 * sz;
		s = int_sqrt(ax * ax + ay * ay);
		if (s == 0)
			return 64'hFFFF_FFFF;
		q = mag64(dot) / s;
		return q > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : q;
	endfunction

	function automatic verdict_t predict_verdict(pair_t p);
		verdict_t v;
		longint x1, y1, x2, y2, d;
		longint l1 [3];
		longint l2 [3];
		x1 = p.first_x;
		y1 = p.first_y;
		x2 = p.second_x;
		y2 = p.second_y;
		for (int i = 0; i < 3; i++) begin
			l1[i] = fm[i][0] * x1 + fm[i][1] * y1 + fm[i][2] * 256;
			l2[i] = fm[0][i] * x2 + fm[1][i] * y2 + fm[2][i] * 256;
		end
		v.result_last = p.pair_last;
		v.degenerate = (l1[0] == 0 && l1[1] == 0) || (l2[0] == 0 && l2[1] == 0);
		if (v.degenerate) begin
			v.abs_distance = SAT32;
			v.is_inlier = 1'b0;
		end else begin
			d = point_line_dist(l1[0], l1[1], l1[2], x2, y2)
				+ point_line_dist(l2[0], l2[1], l2[2], x1, y1);
			if (d > 64'hFFFF_FFFF)
				d = 64'hFFFF_FFFF;
			v.abs_distance = d[31:0];
			v.is_inlier = d < longint'(limit_q8);
		end
		return v;
	endfunction

	// register write over the apb port: setup cycle, then access cycle
	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_COEF_A: begin fm[0][0] = $signed(value[63:32]); fm[0][1] = $signed(value[31:0]); end
			REG_COEF_B: begin fm[0][2] = $signed(value[63:32]); fm[1][0] = $signed(value[31:0]); end
			REG_COEF_C: begin fm[1][1] = $signed(value[63:32]); fm[1][2] = $signed(value[31:0]); end
			REG_COEF_D: begin fm[2][0] = $signed(value[63:32]); fm[2][1] = $signed(value[31:0]); end
			REG_COEF_E: fm[2][2] = $signed(value[31:0]);
			REG_LIMIT:  limit_q8 = value[31:0];
			default: ;
		endcase
	endtask

	// the whole matrix plus the threshold, written only once the pipeline has drained
	task automatic load_setup(logic [31:0] f [9], logic [31:0] lim);
		start <= 1'b0;
		wait (verdicts_due.size() == 0);
		repeat (80) @(posedge clk);
		write_reg(REG_COEF_A, {f[0], f[1]});
		write_reg(REG_COEF_B, {f[2], f[3]});
		write_reg(REG_COEF_C, {f[4], f[5]});
		write_reg(REG_COEF_D, {f[6], f[7]});
		write_reg(REG_COEF_E, {32'h0, f[8]});
		write_reg(REG_LIMIT, {32'h0, lim});
	endtask

	// one input transaction; start stays high into the next item when no gap follows
	task automatic send_pair(pair_t p, bit typed, verdict_t v, bit may_idle);
		row_typed <= typed;
		row_verdict <= v;
		start <= 1'b1;
		point_pair <= p;
		do @(posedge clk); while (busy);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	function automatic pair_t random_pair();
		pair_t p;
		p.first_x = 24'($urandom);
		p.first_y = 24'($urandom);
		p.second_x = 24'($urandom);
		p.second_y = 24'($urandom);
		p.pair_last = 1'($urandom_range(0, 1));
		return p;
	endfunction

	// pure sideways translation: lines are horizontal, so matching rows give inliers
	function automatic pair_t aligned_pair();
		pair_t p;
		int y;
		p = random_pair();
		p.first_x = 24'($signed($urandom_range(0, 1 << 19)) - 262144);
		p.second_x = 24'($signed($urandom_range(0, 1 << 19)) - 262144);
		y = $urandom_range(0, 1 << 18) - (1 << 17);
		p.first_y = 24'(y);
		p.second_y = 24'(y + int'($urandom_range(0, 600)) - 300);
		return p;
	endfunction

	// acceptance and result checking, both sampled at the rising edge
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && start && !busy)
			verdicts_due = {verdicts_due,
				row_typed ? row_verdict : predict_verdict(point_pair)};
		if (arst_n && done) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected verdict %p", $time, verdict);
				mismatch_seen = 1'b1;
			end else begin
				want = verdicts_due.pop_front();
				if (verdict.is_inlier !== want.is_inlier) begin
					$display("%0t: is_inlier expected %0d got %0d", $time,
						want.is_inlier, verdict.is_inlier);
					mismatch_seen = 1'b1;
				end
				if (verdict.abs_distance !== want.abs_distance) begin
					$display("%0t: abs_distance expected %h got %h", $time,
						want.abs_distance, verdict.abs_distance);
					mismatch_seen = 1'b1;
				end
				if (verdict.degenerate !== want.degenerate) begin
					$display("%0t: degenerate expected %0d got %0d", $time,
						want.degenerate, verdict.degenerate);
					mismatch_seen = 1'b1;
				end
				if (verdict.result_last !== want.result_last) begin
					$display("%0t: result_last expected %0d got %0d", $time,
						want.result_last, verdict.result_last);
					mismatch_seen = 1'b1;
				end
			end
		end
	end

	initial begin
		#3ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		row_t rows [$];
		row_t r;
		logic [31:0] f [9];
		logic [31:0] lim;
		verdict_t none;
		pair_t p;
		int n;

		none = '0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				fm[i][j] = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the matrix is zero: every pair has a zero line normal
		foreach (rows[i]) ;
		r.typed = 1'b1;
		r.p = {24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1};
		r.v = {1'b0, SAT32, 1'b1, 1'b1};
		rows = {rows, r};
		r.p = {24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 1'b0};
		r.v = {1'b0, SAT32, 1'b1, 1'b0};
		rows = {rows, r};
		r.p = '0;
		rows = {rows, r};
		foreach (rows[i])
			send_pair(rows[i].p, rows[i].typed, rows[i].v, 1'b1);

		// translation matrix, extremes of the coordinates checked by prediction
		f = '{0, 0, 0, 0, 0, -ONE_F, 0, ONE_F, 0};
		load_setup(f, 32'd512);
		rows.delete();
		r.typed = 1'b0;
		r.v = none;
		r.p = {24'sh7FFFFF, 24'sh000100, 24'sh800000, 24'sh000100, 1'b1};  // same row
		rows = {rows, r};
		r.p = {24'sh000000, 24'sh7FFFFF, 24'sh000000, 24'sh800000, 1'b0};  // far apart
		rows = {rows, r};
		r.p = {24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1};
		rows = {rows, r};
		r.p = {24'sh001000, 24'sh002000, 24'sh003000, 24'sh0020FF, 1'b0};  // just inside
		rows = {rows, r};
		r.p = {24'sh001000, 24'sh002000, 24'sh003000, 24'sh002100, 1'b0};  // just outside
		rows = {rows, r};
		foreach (rows[i])
			send_pair(rows[i].p, rows[i].typed, rows[i].v, 1'b1);

		// extreme coefficients: huge lines, saturated distances
		f = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
		load_setup(f, 32'hFFFF_FFFF);
		for (int i = 0; i < 6; i++)
			send_pair(random_pair(), 1'b0, none, 1'b1);

		// only the third column set: l2 has a zero normal, l1 does not
		f = '{0, 0, ONE_F, 0, 0, 32'h00000001, 0, 0, 32'h80000000};
		load_setup(f, 32'd0);
		for (int i = 0; i < 4; i++)
			send_pair(random_pair(), 1'b0, none, 1'b1);

		// random phases: near-translation matrices in half of them, mostly with matched points
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin
					f = '{0, 0, 0, 0, 0, -ONE_F, 0, ONE_F, 0};
					for (int i = 0; i < 9; i++)
						f[i] = f[i] + $urandom_range(0, 2048) - 1024;
				end
				1: begin
					for (int i = 0; i < 9; i++)
						f[i] = $urandom;
				end
				2: begin
					for (int i = 0; i < 9; i++)
						f[i] = $signed($urandom_range(0, 1 << 12)) - 2048;
				end
				default: begin
					f = '{0, 0, 0, 0, 0, -(ONE_F >> $urandom_range(0, 8)), 0,
						ONE_F >> $urandom_range(0, 8), $urandom_range(0, 1 << 16)};
				end
			endcase
			case (ph)
				1: lim = 32'hFFFF_FFFF;
				5: lim = 32'd0;
				default: lim = $urandom_range(1, 1 << 14);
			endcase
			load_setup(f, lim);
			n = ph == 7 ? 200 : 190;
			for (int i = 0; i < n; i++) begin
				p = ($urandom_range(0, 3) != 0) ? aligned_pair() : random_pair();
				// last phase runs back to back
				send_pair(p, 1'b0, none, ph != 7);
			end
		end

		start <= 1'b0;
		wait (verdicts_due.size() == 0);
		repeat (80) @(posedge clk);
		if (!mismatch_seen)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/eit_pkg.sv
rtl/core/eit_line_gen.sv
rtl/core/eit_norm.sv
rtl/core/eit_sqrt.sv
rtl/core/eit_div.sv
rtl/core/epipolar_inlier_test.sv
bench/testbench.sv
